// ===== rtl/coalescing_deferred_write_buffer_assert.svh =====
// ----------------------------------------------------------------------------
// coalescing deferred write buffer assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef COALESCING_DEFERRED_WRITE_BUFFER_ASSERT_SVH
`define COALESCING_DEFERRED_WRITE_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS
`define CDWB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdwb assertion failed");
`define CDWB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdwb assertion failed");
`else
`define CDWB_ASSERT_IMP(lbl, ante, cons)
`define CDWB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/cdwb_pkg.sv =====
// ----------------------------------------------------------------------------
// cdwb_pkg
// shared types, constants and the key slot map of the write buffer
// ----------------------------------------------------------------------------
package cdwb_pkg;

  localparam int unsigned BUFFER_ENTRIES_DEF = 8;
  localparam int unsigned ADDR_W             = 8;
  localparam int unsigned DATA_W             = 8;
  localparam int unsigned TIME_W             = 32;
  localparam int unsigned IVL_W              = 16;
  localparam int unsigned SLOT_W             = 4;

  localparam logic [IVL_W-1:0]  INTERVAL_RST = IVL_W'(1000);
  localparam logic [ADDR_W-1:0] DIRECT_MAX   = ADDR_W'(6);
  localparam logic [ADDR_W-1:0] ADDR_EXTRA_A = ADDR_W'(20);
  localparam logic [ADDR_W-1:0] ADDR_EXTRA_B = ADDR_W'(60);
  localparam logic [SLOT_W-1:0] SLOT_EXTRA_A = SLOT_W'(7);
  localparam logic [SLOT_W-1:0] SLOT_EXTRA_B = SLOT_W'(8);

  typedef enum logic [1:0] {
    OP_DIRECT,
    OP_DEFER,
    OP_FLUSH
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    logic              force_req;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              known;
  } key_t;

  function automatic key_t map_key(input logic [ADDR_W-1:0] addr);
    key_t k;
    k.slot  = '0;
    k.known = 1'b1;
    if (addr <= DIRECT_MAX) begin
      k.slot = addr[SLOT_W-1:0];
    end else if (addr == ADDR_EXTRA_A) begin
      k.slot = SLOT_EXTRA_A;
    end else if (addr == ADDR_EXTRA_B) begin
      k.slot = SLOT_EXTRA_B;
    end else begin
      k.known = 1'b0;
    end
    return k;
  endfunction

endpackage

// ===== rtl/cdwb_ram.sv =====
// ----------------------------------------------------------------------------
// cdwb_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cdwb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/cdwb_front.sv =====
// ----------------------------------------------------------------------------
// cdwb_front
// accepts request beats and classifies them into buffer commands
// ----------------------------------------------------------------------------
module cdwb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [cdwb_pkg::ADDR_W-1:0]   in_address,
  input  logic [cdwb_pkg::DATA_W-1:0]   in_data_value,
  input  logic                          in_defer,
  input  logic                          in_force_req,
  input  logic [cdwb_pkg::TIME_W-1:0]   in_now_ms,
  output logic                          q_valid,
  input  logic                          q_ready,
  output cdwb_pkg::cmd_t                q_cmd
);

  logic           hold_vld_r, hold_vld_nxt;
  cdwb_pkg::cmd_t hold_cmd_r, hold_cmd_nxt;
  logic           accept;

  assign in_ready = !hold_vld_r || q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    hold_cmd_nxt = hold_cmd_r;
    if (hold_vld_r && q_ready) begin
      hold_vld_nxt = 1'b0;
    end
    if (accept) begin
      hold_vld_nxt           = 1'b1;
      hold_cmd_nxt.addr      = in_address;
      hold_cmd_nxt.value     = in_data_value;
      hold_cmd_nxt.force_req = in_force_req;
      hold_cmd_nxt.now       = in_now_ms;
      if (in_req_type) begin
        hold_cmd_nxt.op = cdwb_pkg::OP_FLUSH;
      end else if (in_defer) begin
        hold_cmd_nxt.op = cdwb_pkg::OP_DEFER;
      end else begin
        hold_cmd_nxt.op = cdwb_pkg::OP_DIRECT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_cmd_r <= hold_cmd_nxt;
  end

  assign q_valid = hold_vld_r;
  assign q_cmd   = hold_cmd_r;

endmodule

// ===== rtl/cdwb_fifo.sv =====
// ----------------------------------------------------------------------------
// cdwb_fifo
// two entry command queue between the front and the back
// ----------------------------------------------------------------------------
module cdwb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  cdwb_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cdwb_pkg::cmd_t pop_cmd
);

  cdwb_pkg::cmd_t buf_r [2];
  logic [1:0]     fill_r, fill_nxt;
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic           push, pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_cmd    = buf_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wp_nxt   = push ? !wp_r : wp_r;
    rp_nxt   = pop ? !rp_r : rp_r;
    fill_nxt = fill_r;
    unique case ({push, pop})
      2'b10:   fill_nxt = fill_r + 2'd1;
      2'b01:   fill_nxt = fill_r - 2'd1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/cdwb_back.sv =====
// ----------------------------------------------------------------------------
// cdwb_back
// executes buffer commands: direct writes, coalescing search, drains
// ----------------------------------------------------------------------------
`include "coalescing_deferred_write_buffer_assert.svh"

module cdwb_back #(
  parameter int unsigned BUFFER_ENTRIES = cdwb_pkg::BUFFER_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cdwb_pkg::IVL_W-1:0]    cfg_flush_interval_ms,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  cdwb_pkg::cmd_t                q_cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cdwb_pkg::SLOT_W-1:0]   out_key_slot,
  output logic [cdwb_pkg::ADDR_W-1:0]   out_store_address,
  output logic [cdwb_pkg::DATA_W-1:0]   out_store_value,
  output logic                          out_key_known,
  output logic                          out_last
);

  localparam int unsigned IDX_W = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(BUFFER_ENTRIES + 1);
  localparam int unsigned ENT_W = cdwb_pkg::ADDR_W + cdwb_pkg::DATA_W;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(BUFFER_ENTRIES);

  cdwb_pkg::state_t state_r, state_nxt;
  cdwb_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] dat_idx_r, dat_idx_nxt;
  logic             dat_vld_r, dat_vld_nxt;
  logic [cdwb_pkg::TIME_W-1:0] last_flush_r, last_flush_nxt;
  logic [cdwb_pkg::IVL_W-1:0]  interval_r;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_load;
  logic [cdwb_pkg::ADDR_W-1:0] out_addr_r, load_addr;
  logic [cdwb_pkg::DATA_W-1:0] out_value_r, load_value;
  logic                        out_last_r, load_last;
  cdwb_pkg::key_t              out_key_r;
  logic                        out_free;

  logic                        ram_we, ram_re;
  logic [IDX_W-1:0]            ram_waddr, ram_raddr;
  logic [ENT_W-1:0]            ram_wdata, ram_rdata;
  logic [cdwb_pkg::ADDR_W-1:0] rd_addr;
  logic [cdwb_pkg::DATA_W-1:0] rd_value;
  logic [cdwb_pkg::TIME_W-1:0] elapsed;
  logic                        take, rd_more;
  logic                        drain_done;

  cdwb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (BUFFER_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready  = 1'b1;
  assign rd_addr    = ram_rdata[ENT_W-1:cdwb_pkg::DATA_W];
  assign rd_value   = ram_rdata[cdwb_pkg::DATA_W-1:0];
  assign out_free   = !out_valid_r || out_ready;
  assign elapsed    = q_cmd.now - last_flush_r;
  assign rd_more    = (rd_idx_r < count_r);
  assign drain_done = (state_r == cdwb_pkg::ST_DRAIN) && (state_nxt == cdwb_pkg::ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    dat_idx_nxt    = dat_idx_r;
    dat_vld_nxt    = dat_vld_r;
    last_flush_nxt = last_flush_r;
    q_ready        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = {cmd_r.addr, cmd_r.value};
    ram_re         = 1'b0;
    ram_raddr      = rd_idx_r[IDX_W-1:0];
    out_load       = 1'b0;
    load_addr      = rd_addr;
    load_value     = rd_value;
    load_last      = 1'b0;
    take           = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;

    unique case (state_r)
      cdwb_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            cdwb_pkg::OP_DIRECT: begin
              if (out_free) begin
                q_ready    = 1'b1;
                out_load   = 1'b1;
                load_addr  = q_cmd.addr;
                load_value = q_cmd.value;
                load_last  = 1'b1;
              end
            end
            cdwb_pkg::OP_FLUSH: begin
              q_ready = 1'b1;
              if (count_r != '0 &&
                  (q_cmd.force_req || elapsed >= {{(cdwb_pkg::TIME_W-cdwb_pkg::IVL_W){1'b0}},
                                                  interval_r})) begin
                cmd_nxt        = q_cmd;
                last_flush_nxt = q_cmd.now;
                rd_idx_nxt     = '0;
                dat_vld_nxt    = 1'b0;
                state_nxt      = cdwb_pkg::ST_DRAIN;
              end
            end
            cdwb_pkg::OP_DEFER: begin
              q_ready     = 1'b1;
              cmd_nxt     = q_cmd;
              rd_idx_nxt  = '0;
              dat_vld_nxt = 1'b0;
              if (count_r == FULL) begin
                last_flush_nxt = q_cmd.now;
                state_nxt      = cdwb_pkg::ST_DRAIN;
              end else begin
                state_nxt = cdwb_pkg::ST_SEARCH;
              end
            end
            default: begin
              q_ready = 1'b1;
            end
          endcase
        end
      end

      cdwb_pkg::ST_SEARCH: begin
        priority if (dat_vld_r && rd_addr == cmd_r.addr) begin
          // same address pending: overwrite its value
          ram_we      = 1'b1;
          ram_waddr   = dat_idx_r[IDX_W-1:0];
          dat_vld_nxt = 1'b0;
          state_nxt   = cdwb_pkg::ST_IDLE;
        end else if (rd_more) begin
          ram_re      = 1'b1;
          dat_idx_nxt = rd_idx_r;
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          dat_vld_nxt = 1'b1;
        end else begin
          // no match: append
          ram_we      = 1'b1;
          ram_waddr   = count_r[IDX_W-1:0];
          count_nxt   = count_r + CNT_W'(1);
          dat_vld_nxt = 1'b0;
          state_nxt   = cdwb_pkg::ST_IDLE;
        end
      end

      cdwb_pkg::ST_DRAIN: begin
        take = dat_vld_r && out_free;
        if (take) begin
          out_load    = 1'b1;
          load_last   = (dat_idx_r + CNT_W'(1) == count_r);
          dat_vld_nxt = 1'b0;
        end
        if (!dat_vld_r || take) begin
          if (rd_more) begin
            ram_re      = 1'b1;
            dat_idx_nxt = rd_idx_r;
            rd_idx_nxt  = rd_idx_r + CNT_W'(1);
            dat_vld_nxt = 1'b1;
          end else begin
            // all entries out; a full-buffer write becomes the only entry
            state_nxt = cdwb_pkg::ST_IDLE;
            if (cmd_r.op == cdwb_pkg::OP_DEFER) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              count_nxt = CNT_W'(1);
            end else begin
              count_nxt = '0;
            end
          end
        end
      end

      default: begin
        state_nxt = cdwb_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cdwb_pkg::ST_IDLE;
      count_r      <= '0;
      dat_vld_r    <= 1'b0;
      last_flush_r <= '0;
      interval_r   <= cdwb_pkg::INTERVAL_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      dat_vld_r    <= dat_vld_nxt;
      last_flush_r <= last_flush_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        interval_r <= cfg_flush_interval_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    rd_idx_r  <= rd_idx_nxt;
    dat_idx_r <= dat_idx_nxt;
    if (out_load) begin
      out_addr_r  <= load_addr;
      out_value_r <= load_value;
      out_last_r  <= load_last;
      out_key_r   <= cdwb_pkg::map_key(load_addr);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key_slot      = out_key_r.slot;
  assign out_key_known     = out_key_r.known;
  assign out_store_address = out_addr_r;
  assign out_store_value   = out_value_r;
  assign out_last          = out_last_r;

  `CDWB_ASSERT_IMP(a_count_bound, 1'b1, count_r <= FULL)
  `CDWB_ASSERT_IMP(a_search_idx, state_r == cdwb_pkg::ST_SEARCH, rd_idx_r <= count_r)
  `CDWB_ASSERT_NXT(a_drain_exit, drain_done, count_r <= CNT_W'(1))

endmodule

// ===== rtl/coalescing_deferred_write_buffer.sv =====
// ----------------------------------------------------------------------------
// coalescing_deferred_write_buffer
// write-combining buffer in front of a byte-wide settings store
//
//   channel  prefix  direction  beat
//   request  in_     input      write or flush request
//   result   out_    output     one store write, last marks end of request
//   config   cfg_    input      flush interval in ms
//
// a direct write's result passes the front holding register, the queue and
// the back end's output register. in the back end one entry ram read per
// cycle bounds the address search and, while results are taken, the drain.
// a two entry queue lets the front keep taking requests while the back works.
// no clearing pass after reset; entries beyond the fill count are never read.
// ----------------------------------------------------------------------------
module coalescing_deferred_write_buffer #(
  parameter int unsigned BUFFER_ENTRIES = cdwb_pkg::BUFFER_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [cdwb_pkg::ADDR_W-1:0]   in_address,
  input  logic [cdwb_pkg::DATA_W-1:0]   in_data_value,
  input  logic                          in_defer,
  input  logic                          in_force_req,
  input  logic [cdwb_pkg::TIME_W-1:0]   in_now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cdwb_pkg::SLOT_W-1:0]   out_key_slot,
  output logic [cdwb_pkg::ADDR_W-1:0]   out_store_address,
  output logic [cdwb_pkg::DATA_W-1:0]   out_store_value,
  output logic                          out_key_known,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cdwb_pkg::IVL_W-1:0]    cfg_flush_interval_ms
);

  logic           fq_valid, fq_ready;
  cdwb_pkg::cmd_t fq_cmd;
  logic           qb_valid, qb_ready;
  cdwb_pkg::cmd_t qb_cmd;

  cdwb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_address    (in_address),
    .in_data_value (in_data_value),
    .in_defer      (in_defer),
    .in_force_req  (in_force_req),
    .in_now_ms     (in_now_ms),
    .q_valid       (fq_valid),
    .q_ready       (fq_ready),
    .q_cmd         (fq_cmd)
  );

  cdwb_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  cdwb_back #(
    .BUFFER_ENTRIES (BUFFER_ENTRIES)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_flush_interval_ms (cfg_flush_interval_ms),
    .q_valid               (qb_valid),
    .q_ready               (qb_ready),
    .q_cmd                 (qb_cmd),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_key_slot          (out_key_slot),
    .out_store_address     (out_store_address),
    .out_store_value       (out_store_value),
    .out_key_known         (out_key_known),
    .out_last              (out_last)
  );

endmodule

// ===== sim/cdwb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdwb_checker
// watches the request, result and config beats of the write buffer, keeps
// its own copy of the pending entries and the flush timer, predicts every
// store write and compares each result beat with the oldest prediction
// ----------------------------------------------------------------------------
module cdwb_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [cdwb_pkg::ADDR_W-1:0] in_address,
  input  logic [cdwb_pkg::DATA_W-1:0] in_data_value,
  input  logic                        in_defer,
  input  logic                        in_force_req,
  input  logic [cdwb_pkg::TIME_W-1:0] in_now_ms,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [cdwb_pkg::SLOT_W-1:0] out_key_slot,
  input  logic [cdwb_pkg::ADDR_W-1:0] out_store_address,
  input  logic [cdwb_pkg::DATA_W-1:0] out_store_value,
  input  logic                        out_key_known,
  input  logic                        out_last,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [cdwb_pkg::IVL_W-1:0]  cfg_flush_interval_ms,
  output int                          error_count,
  output int                          writes_outstanding
);

  typedef struct packed {
    logic [cdwb_pkg::SLOT_W-1:0] slot;
    logic [cdwb_pkg::ADDR_W-1:0] addr;
    logic [cdwb_pkg::DATA_W-1:0] value;
    logic                        known;
    logic                        last;
  } store_write_t;

  store_write_t                expected_writes[$];
  store_write_t                seen_write;
  store_write_t                want_write;
  logic [cdwb_pkg::ADDR_W-1:0] held_addr [cdwb_pkg::BUFFER_ENTRIES_DEF];
  logic [cdwb_pkg::DATA_W-1:0] held_value [cdwb_pkg::BUFFER_ENTRIES_DEF];
  int unsigned                 held_count;
  logic [cdwb_pkg::TIME_W-1:0] last_flush_ms;
  logic [cdwb_pkg::IVL_W-1:0]  flush_interval;
  cdwb_pkg::op_t               req_op;

  function automatic store_write_t to_store_write(input logic [cdwb_pkg::ADDR_W-1:0] addr,
                                                  input logic [cdwb_pkg::DATA_W-1:0] value,
                                                  input logic                        last);
    store_write_t w;
    w.slot  = '0;
    w.addr  = addr;
    w.value = value;
    w.known = 1'b1;
    w.last  = last;
    case (addr)
      cdwb_pkg::ADDR_EXTRA_A: w.slot = cdwb_pkg::SLOT_EXTRA_A;
      cdwb_pkg::ADDR_EXTRA_B: w.slot = cdwb_pkg::SLOT_EXTRA_B;
      default: begin
        if (addr <= cdwb_pkg::DIRECT_MAX) begin
          w.slot = addr[cdwb_pkg::SLOT_W-1:0];
        end else begin
          w.known = 1'b0;
        end
      end
    endcase
    return w;
  endfunction

  task automatic drain_held(input logic [cdwb_pkg::TIME_W-1:0] now);
    for (int i = 0; i < held_count; i++) begin
      expected_writes.push_back(to_store_write(held_addr[i], held_value[i],
                                               i + 1 == held_count));
    end
    held_count    = 0;
    last_flush_ms = now;
  endtask

  task automatic predict_store_writes(input cdwb_pkg::op_t               op,
                                      input logic [cdwb_pkg::ADDR_W-1:0] addr,
                                      input logic [cdwb_pkg::DATA_W-1:0] value,
                                      input logic                        force_req,
                                      input logic [cdwb_pkg::TIME_W-1:0] now);
    logic [cdwb_pkg::TIME_W-1:0] elapsed;
    bit                          merged;
    elapsed = now - last_flush_ms;
    merged  = 1'b0;
    case (op)
      cdwb_pkg::OP_FLUSH: begin
        if (held_count != 0 &&
            (force_req || elapsed >= cdwb_pkg::TIME_W'(flush_interval))) begin
          drain_held(now);
        end
      end
      cdwb_pkg::OP_DIRECT: begin
        expected_writes.push_back(to_store_write(addr, value, 1'b1));
      end
      default: begin
        // full buffer drains first, even when the address is already held
        if (held_count == cdwb_pkg::BUFFER_ENTRIES_DEF) begin
          drain_held(now);
        end
        for (int i = 0; i < held_count; i++) begin
          if (!merged && held_addr[i] == addr) begin
            held_value[i] = value;
            merged        = 1'b1;
          end
        end
        if (!merged) begin
          held_addr[held_count]  = addr;
          held_value[held_count] = value;
          held_count++;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_writes.delete();
      held_count     = 0;
      last_flush_ms  = '0;
      flush_interval = cdwb_pkg::INTERVAL_RST;
      error_count    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        flush_interval = cfg_flush_interval_ms;
      end
      if (out_valid && out_ready) begin
        seen_write.slot  = out_key_slot;
        seen_write.addr  = out_store_address;
        seen_write.value = out_store_value;
        seen_write.known = out_key_known;
        seen_write.last  = out_last;
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected store write beat slot %0d addr %0h value %0h %0b %0b",
                   $time, seen_write.slot, seen_write.addr, seen_write.value,
                   seen_write.known, seen_write.last);
          error_count++;
        end else begin
          want_write = expected_writes.pop_front();
          if (seen_write !== want_write) begin
            $display({"%0t: store write mismatch expected slot %0d addr %0h value %0h",
                      " known %0b last %0b, actual slot %0d addr %0h value %0h",
                      " known %0b last %0b"},
                     $time, want_write.slot, want_write.addr, want_write.value,
                     want_write.known, want_write.last,
                     seen_write.slot, seen_write.addr, seen_write.value,
                     seen_write.known, seen_write.last);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_req_type) begin
          req_op = cdwb_pkg::OP_FLUSH;
        end else if (in_defer) begin
          req_op = cdwb_pkg::OP_DEFER;
        end else begin
          req_op = cdwb_pkg::OP_DIRECT;
        end
        predict_store_writes(req_op, in_address, in_data_value, in_force_req, in_now_ms);
      end
    end
    writes_outstanding = expected_writes.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives write and flush requests and flush interval settings into the
// write buffer under random sender gaps and receiver stalls; the checker
// beside the block predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned ITEMS_PER_PHASE = 39;
  localparam int unsigned PHASES          = 6;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_req_type;
  logic [cdwb_pkg::ADDR_W-1:0] in_address;
  logic [cdwb_pkg::DATA_W-1:0] in_data_value;
  logic                        in_defer;
  logic                        in_force_req;
  logic [cdwb_pkg::TIME_W-1:0] in_now_ms;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [cdwb_pkg::SLOT_W-1:0] out_key_slot;
  logic [cdwb_pkg::ADDR_W-1:0] out_store_address;
  logic [cdwb_pkg::DATA_W-1:0] out_store_value;
  logic                        out_key_known;
  logic                        out_last;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [cdwb_pkg::IVL_W-1:0]  cfg_flush_interval_ms;

  int                          error_count;
  int                          writes_outstanding;
  int                          in_idle_pct;
  int                          out_stall_pct;
  int unsigned                 cycle_count;
  logic [cdwb_pkg::TIME_W-1:0] now_t;

  coalescing_deferred_write_buffer #(
    .BUFFER_ENTRIES(cdwb_pkg::BUFFER_ENTRIES_DEF)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_req_type           (in_req_type),
    .in_address            (in_address),
    .in_data_value         (in_data_value),
    .in_defer              (in_defer),
    .in_force_req          (in_force_req),
    .in_now_ms             (in_now_ms),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_key_slot          (out_key_slot),
    .out_store_address     (out_store_address),
    .out_store_value       (out_store_value),
    .out_key_known         (out_key_known),
    .out_last              (out_last),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_flush_interval_ms (cfg_flush_interval_ms)
  );

  cdwb_checker i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_req_type           (in_req_type),
    .in_address            (in_address),
    .in_data_value         (in_data_value),
    .in_defer              (in_defer),
    .in_force_req          (in_force_req),
    .in_now_ms             (in_now_ms),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_key_slot          (out_key_slot),
    .out_store_address     (out_store_address),
    .out_store_value       (out_store_value),
    .out_key_known         (out_key_known),
    .out_last              (out_last),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_flush_interval_ms (cfg_flush_interval_ms),
    .error_count           (error_count),
    .writes_outstanding    (writes_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= out_stall_pct);
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_item(input cdwb_pkg::op_t               op,
                           input logic [cdwb_pkg::ADDR_W-1:0] addr,
                           input logic [cdwb_pkg::DATA_W-1:0] value,
                           input logic                        force_req,
                           input logic [cdwb_pkg::TIME_W-1:0] now);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_req_type   = (op == cdwb_pkg::OP_FLUSH);
    in_defer      = (op == cdwb_pkg::OP_FLUSH) ? 1'($urandom_range(1))
                                               : (op == cdwb_pkg::OP_DEFER);
    in_address    = addr;
    in_data_value = value;
    in_force_req  = force_req;
    in_now_ms     = now;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_interval(input logic [cdwb_pkg::IVL_W-1:0] interval);
    cfg_flush_interval_ms = interval;
    cfg_valid             = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // absorbed writes leave no trace in the checker, so wait out the back end too
  task automatic settle();
    in_valid = 1'b0;
    while (writes_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int                          r;
    cdwb_pkg::op_t               op;
    logic [cdwb_pkg::ADDR_W-1:0] addr;
    logic [cdwb_pkg::TIME_W-1:0] step;

    rst_n                 = 1'b0;
    in_valid              = 1'b0;
    in_req_type           = 1'b0;
    in_address            = '0;
    in_data_value         = '0;
    in_defer              = 1'b0;
    in_force_req          = 1'b0;
    in_now_ms             = '0;
    cfg_valid             = 1'b0;
    cfg_flush_interval_ms = '0;
    in_idle_pct           = 17;
    out_stall_pct         = 45;
    now_t                 = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed part runs with the reset interval
    send_item(cdwb_pkg::OP_FLUSH, 8'h00, 8'h00, 1'b1, 32'd10);
    send_item(cdwb_pkg::OP_DIRECT, 8'h00, 8'hFF, 1'b1, 32'd20);
    send_item(cdwb_pkg::OP_DIRECT, 8'hFF, 8'h00, 1'b0, 32'd30);
    send_item(cdwb_pkg::OP_DIRECT, cdwb_pkg::ADDR_EXTRA_A, 8'hA5, 1'b0, 32'd40);
    send_item(cdwb_pkg::OP_DIRECT, cdwb_pkg::ADDR_EXTRA_B, 8'h5A, 1'b0, 32'd50);
    send_item(cdwb_pkg::OP_DEFER, 8'd6, 8'h11, 1'b0, 32'd100);
    send_item(cdwb_pkg::OP_DEFER, 8'd6, 8'h22, 1'b1, 32'd110);
    send_item(cdwb_pkg::OP_DEFER, 8'd7, 8'h33, 1'b0, 32'd120);
    send_item(cdwb_pkg::OP_FLUSH, 8'hFF, 8'hFF, 1'b0, 32'd500);
    send_item(cdwb_pkg::OP_FLUSH, 8'h00, 8'h00, 1'b0, 32'd1000);
    for (int a = 0; a < 7; a++) begin
      send_item(cdwb_pkg::OP_DEFER, cdwb_pkg::ADDR_W'(a), cdwb_pkg::DATA_W'(a * 16 + 1),
                1'b0, 32'd1500);
    end
    send_item(cdwb_pkg::OP_DEFER, cdwb_pkg::ADDR_EXTRA_A, 8'h77, 1'b0, 32'd1500);
    send_item(cdwb_pkg::OP_DEFER, 8'd3, 8'h99, 1'b0, 32'd2000);
    send_item(cdwb_pkg::OP_FLUSH, 8'h00, 8'h00, 1'b1, 32'd2001);
    send_item(cdwb_pkg::OP_DEFER, cdwb_pkg::ADDR_EXTRA_B, 8'hC3, 1'b0, 32'd2002);
    send_item(cdwb_pkg::OP_FLUSH, 8'h00, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_item(cdwb_pkg::OP_DEFER, 8'd1, 8'h3C, 1'b0, 32'h0000_0010);
    send_item(cdwb_pkg::OP_FLUSH, 8'h00, 8'h00, 1'b0, 32'h0000_0100);
    send_item(cdwb_pkg::OP_FLUSH, 8'h00, 8'h00, 1'b0, 32'h0000_03E7);
    now_t = 32'h0000_0400;

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       write_interval(cdwb_pkg::IVL_W'($urandom_range(3000, 200)));
        1:       write_interval('1);
        2:       write_interval('0);
        3:       write_interval(cdwb_pkg::IVL_W'($urandom_range(500, 1)));
        4:       write_interval(cdwb_pkg::IVL_W'(1));
        default: write_interval(cdwb_pkg::IVL_W'($urandom_range(65535)));
      endcase
      in_idle_pct   = (ph < 2) ? 17 : (ph < 4) ? 45 : 0;
      out_stall_pct = (ph < 2) ? 45 : (ph < 4) ? 17 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (r < 50) begin
          op = cdwb_pkg::OP_DEFER;
        end else if (r < 70) begin
          op = cdwb_pkg::OP_DIRECT;
        end else begin
          op = cdwb_pkg::OP_FLUSH;
        end
        // mostly a small pool of addresses so that writes coalesce
        if ($urandom_range(99) < 70) begin
          case ($urandom_range(11))
            7:       addr = cdwb_pkg::ADDR_EXTRA_A;
            8:       addr = cdwb_pkg::ADDR_EXTRA_B;
            9:       addr = 8'd7;
            10:      addr = 8'hFF;
            11:      addr = cdwb_pkg::ADDR_W'($urandom_range(255));
            default: addr = cdwb_pkg::ADDR_W'($urandom_range(6));
          endcase
        end else begin
          addr = cdwb_pkg::ADDR_W'($urandom_range(255));
        end
        r = $urandom_range(99);
        if (r < 60) begin
          step = cdwb_pkg::TIME_W'($urandom_range(300));
        end else if (r < 90) begin
          step = cdwb_pkg::TIME_W'($urandom_range(3000));
        end else if (r < 98) begin
          step = cdwb_pkg::TIME_W'($urandom_range(70000));
        end else begin
          step = $urandom;
        end
        now_t = now_t + step;
        send_item(op, addr, cdwb_pkg::DATA_W'($urandom), 1'($urandom_range(1)), now_t);
      end
    end

    settle();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cdwb_pkg.sv
rtl/cdwb_ram.sv
rtl/cdwb_front.sv
rtl/cdwb_fifo.sv
rtl/cdwb_back.sv
rtl/coalescing_deferred_write_buffer.sv
sim/cdwb_checker.sv
sim/tb_top.sv
